// ----- hdl/imc_pkg.sv -----
package imc_pkg;

  // field widths of the stream beats
  localparam int unsigned FIELD_W     = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned IN_TDATA_W  = 3 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = COUNT_W;
  localparam int unsigned OUT_TUSER_W = 2;

  // input kind, carried on in_tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // one result beat
  typedef struct packed {
    logic               status;
    logic               is_fresh;
    logic [COUNT_W-1:0] fresh_total;
  } result_t;

endpackage

// ----- hdl/interval_membership_counter.sv -----
// Range match table. A load beat (in_tuser = 0) appends the inclusive range
// [range_low, range_high] to a table of up to MAX_RANGES entries; its result is
// registered from state S_DONE, and the next beat is taken back in S_IDLE.
// A load into a full table is refused with status = 1. A query beat
// (in_tuser = 1) walks the stored ranges through the single read port of the
// table memory, one entry per cycle. With N stored ranges it issues N reads in
// S_SCAN and compares each entry read, then waits for the last read to drain
// before S_DONE registers its result and the sequencer returns to S_IDLE.
// A result that is still waiting on the output register holds the sequencer
// in S_DONE. is_fresh reports a hit in
// any range, and fresh_total counts hitting queries, saturating at 2^32-1. One
// item is worked at a time; the next beat is taken while the previous result
// waits on the output register. Values are compared in their low ID_WIDTH bits.
module interval_membership_counter
  import imc_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 256,
  parameter int unsigned ID_WIDTH   = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: range_low [63:0], range_high [127:64], item_id [191:128]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: func [0]
  input  logic                   in_tuser,
  // out_tdata: fresh_total [31:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: is_fresh [0], status [1]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  // input field slices
  logic [ID_WIDTH-1:0] range_low;
  logic [ID_WIDTH-1:0] range_high;
  logic [ID_WIDTH-1:0] item_id;
  logic                in_accept;

  assign range_low  = in_tdata[ID_WIDTH-1:0];
  assign range_high = in_tdata[FIELD_W +: ID_WIDTH];
  assign item_id    = in_tdata[2*FIELD_W +: ID_WIDTH];
  assign in_accept  = in_tvalid && in_tready;

  // control state
  state_t         state_r, state_nxt;
  logic [CW-1:0]  stored_r, stored_nxt;
  logic [CW-1:0]  issue_r, issue_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic           hit_r, hit_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;

  // payload state
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic                status_r, status_nxt;
  result_t             res_r, res_nxt;

  // table memory: {upper, lower} per entry
  logic [2*ID_WIDTH-1:0] mem [MAX_RANGES];
  logic [2*ID_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [ID_WIDTH-1:0]   rd_low;
  logic [ID_WIDTH-1:0]   rd_high;

  assign rd_low  = rd_data_r[ID_WIDTH-1:0];
  assign rd_high = rd_data_r[2*ID_WIDTH-1:ID_WIDTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[stored_r[AW-1:0]] <= {range_high, range_low};
    end
    if (mem_re) begin
      rd_data_r <= mem[issue_r[AW-1:0]];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.fresh_total;
  assign out_tuser  = {res_r.status, res_r.is_fresh};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    stored_nxt    = stored_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    id_nxt        = id_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          hit_nxt   = 1'b0;
          id_nxt    = item_id;
          issue_nxt = '0;
          state_nxt = (in_tuser == FUNC_QUERY) ? S_SCAN : S_DONE;
          status_nxt = STATUS_OK;
          if (in_tuser == FUNC_LOAD) begin
            if (stored_r == CW'(MAX_RANGES)) begin
              status_nxt = STATUS_FULL;
            end else begin
              mem_we     = 1'b1;
              stored_nxt = stored_r + 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle
        if (rd_vld_r && (rd_low <= id_r) && (id_r <= rd_high)) begin
          hit_nxt = 1'b1;
        end
        // issue the next read, or finish once the pipe has drained
        if (issue_r != stored_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          if (hit_r && (count_r != '1)) begin
            count_nxt = count_r + 1'b1;
          end
          res_nxt.status   = status_r;
          res_nxt.is_fresh = hit_r;
          res_nxt.fresh_total = (hit_r && (count_r != '1)) ? count_r + 1'b1 : count_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stored_r    <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  // table fill never passes its depth
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CW'(MAX_RANGES))
    else $error("range count beyond table depth");

  // accepted load into a non-full table appends exactly one entry
  a_load_append: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser == FUNC_LOAD) && (stored_r != CW'(MAX_RANGES)))
      |=> (stored_r == $past(stored_r) + 1'b1))
    else $error("load did not append");

  // match count only moves up
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("match count decreased");

  // read data only in flight during a scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("table read outside scan");

  // a refused load never reports a hit
  a_status_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.status && res_r.is_fresh))
    else $error("refused load flagged as hit");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import imc_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned RANDOM_ITEMS = 1280;
  localparam logic [FIELD_W-1:0] ID_MAX = '1;
  localparam logic [FIELD_W-1:0] JUNK   = 64'hC3A5_5A3C_0FF0_F00F;

  // one row of the directed table
  typedef struct {
    logic               func;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] id;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = FUNC_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  interval_membership_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // range table mirror and match count
  logic [FIELD_W-1:0] bound_lo [TABLE_DEPTH];
  logic [FIELD_W-1:0] bound_hi [TABLE_DEPTH];
  int unsigned        ranges_held = 0;
  logic [COUNT_W-1:0] hit_count   = '0;

  result_t   pending_results [$];
  stim_row_t dir_rows [$];

  int unsigned errors        = 0;
  int unsigned results_seen  = 0;
  int unsigned loads_stored  = 0;
  int unsigned loads_refused = 0;
  int unsigned lookups       = 0;
  int unsigned lookup_hits   = 0;
  int unsigned rx_stall      = 0;
  int unsigned rx_calm       = 0;
  bit          tx_calm       = 1'b0;

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    if (errors < 50)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // expected beat for one accepted item; updates the mirrored table
  function automatic result_t predict_match(logic func, logic [FIELD_W-1:0] lo,
                                            logic [FIELD_W-1:0] hi,
                                            logic [FIELD_W-1:0] id);
    result_t r;
    r.status   = STATUS_OK;
    r.is_fresh = 1'b0;
    if (func == FUNC_LOAD) begin
      if (ranges_held >= TABLE_DEPTH) begin
        r.status = STATUS_FULL;
        loads_refused++;
      end else begin
        bound_lo[ranges_held] = lo;
        bound_hi[ranges_held] = hi;
        ranges_held++;
        loads_stored++;
      end
    end else begin
      lookups++;
      for (int k = 0; k < ranges_held; k++)
        if (id >= bound_lo[k] && id <= bound_hi[k]) r.is_fresh = 1'b1;
      if (r.is_fresh) begin
        lookup_hits++;
        if (hit_count != '1) hit_count++;
      end
    end
    r.fresh_total = hit_count;
    return r;
  endfunction

  function automatic result_t beat_of(logic fresh, int unsigned total, logic st);
    result_t r;
    r.status      = st;
    r.is_fresh    = fresh;
    r.fresh_total = total;
    return r;
  endfunction

  function automatic void add_row(logic func, logic [FIELD_W-1:0] lo,
                                  logic [FIELD_W-1:0] hi, logic [FIELD_W-1:0] id,
                                  bit typed, result_t want);
    stim_row_t row;
    row.func  = func;
    row.lo    = lo;
    row.hi    = hi;
    row.id    = id;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [FIELD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random range: mostly narrow, some wide, some single points, some inverted
  task automatic make_range(output logic [FIELD_W-1:0] lo, output logic [FIELD_W-1:0] hi);
    int unsigned        pick;
    logic [FIELD_W-1:0] span;
    logic [FIELD_W:0]   top;
    pick = $urandom_range(0, 99);
    lo   = rand64();
    if (pick < 55) span = FIELD_W'($urandom_range(0, 1000));
    else if (pick < 75) span = {32'd0, $urandom};
    else if (pick < 85) span = rand64() >> $urandom_range(1, 40);
    else span = '0;
    top = {1'b0, lo} + span;
    hi  = top[FIELD_W] ? ID_MAX : top[FIELD_W-1:0];
    if (pick >= 92) begin
      hi = rand64();
      lo = hi + FIELD_W'(1 + $urandom_range(0, 1000));
      if (lo <= hi) lo = ID_MAX;
    end
  endtask

  // lookup ID: mostly inside or at the edges of a stored range
  task automatic pick_id(output logic [FIELD_W-1:0] id);
    int unsigned        pick;
    int unsigned        k;
    logic [FIELD_W-1:0] width;
    pick = $urandom_range(0, 99);
    if (ranges_held == 0 || pick < 15) begin
      id = rand64();
    end else if (pick < 20) begin
      id = pick[0] ? ID_MAX : '0;
    end else begin
      k     = $urandom_range(0, ranges_held - 1);
      width = bound_hi[k] - bound_lo[k];
      if (pick < 50 && bound_lo[k] <= bound_hi[k])
        id = (width == ID_MAX) ? rand64() : bound_lo[k] + rand64() % (width + 1);
      else if (pick < 62) id = bound_lo[k];
      else if (pick < 74) id = bound_hi[k];
      else if (pick < 87) id = bound_lo[k] - 1;
      else id = bound_hi[k] + 1;
    end
  endtask

  // drive one beat, wait for the handshake, then log what should come back
  task automatic send_beat(stim_row_t row);
    result_t pred;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= row.func;
    in_tdata  <= {row.id, row.hi, row.lo};
    do @(posedge clk); while (!in_tready);
    pred = predict_match(row.func, row.lo, row.hi, row.id);
    pending_results.push_back(row.typed ? row.want : pred);
    gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every pending result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(50, 400);
      else if ($urandom_range(0, 99) < 30) rx_stall = pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", FIELD_W'(out_tdata), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata != want.fresh_total)
          report_mismatch("fresh_total", FIELD_W'(out_tdata), FIELD_W'(want.fresh_total));
        if (out_tuser[0] != want.is_fresh)
          report_mismatch("is_fresh", FIELD_W'(out_tuser[0]), FIELD_W'(want.is_fresh));
        if (out_tuser[1] != want.status)
          report_mismatch("status", FIELD_W'(out_tuser[1]), FIELD_W'(want.status));
      end
    end
  end

  initial begin
    stim_row_t row;
    result_t   idle_beat;
    idle_beat = beat_of(1'b0, 0, STATUS_OK);

    // empty table, extremes, inverted ranges, overlap
    add_row(FUNC_QUERY, JUNK, ID_MAX, '0, 1, idle_beat);
    add_row(FUNC_QUERY, ID_MAX, JUNK, ID_MAX, 1, idle_beat);
    add_row(FUNC_LOAD, '0, '0, JUNK, 1, idle_beat);
    add_row(FUNC_LOAD, ID_MAX, ID_MAX, '0, 1, idle_beat);
    add_row(FUNC_LOAD, ID_MAX, '0, ID_MAX, 1, idle_beat);
    add_row(FUNC_LOAD, 64'd100, 64'd50, JUNK, 1, idle_beat);
    add_row(FUNC_QUERY, ID_MAX, ID_MAX, '0, 1, beat_of(1'b1, 1, STATUS_OK));
    add_row(FUNC_QUERY, '0, '0, ID_MAX, 1, beat_of(1'b1, 2, STATUS_OK));
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd1, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd75, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, ID_MAX - 1, 0, idle_beat);
    add_row(FUNC_LOAD, 64'd1000, 64'd2000, JUNK, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd999, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd1000, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd1500, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd2000, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd2001, 0, idle_beat);
    add_row(FUNC_LOAD, 64'd1500, 64'd3000, JUNK, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd1800, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'd2500, 0, idle_beat);
    add_row(FUNC_LOAD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'h8000_0000_0000_0000, 0, idle_beat);
    add_row(FUNC_QUERY, JUNK, JUNK, 64'h5555_5555_5555_5554, 0, idle_beat);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    drain_results();

    // random part: about a quarter loads, so the table fills and then refuses
    row.typed = 0;
    row.want  = idle_beat;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      row.func = ($urandom_range(0, 99) < 25) ? FUNC_LOAD : FUNC_QUERY;
      make_range(row.lo, row.hi);
      pick_id(row.id);
      send_beat(row);
    end

    drain_results();
    repeat (TABLE_DEPTH + 16) @(posedge clk);

    $display("covered %0d range loads (%0d refused on a full table), %0d lookups with %0d hits",
             loads_stored + loads_refused, loads_refused, lookups, lookup_hits);
    $display("%0d result beats checked, %0d mismatches", results_seen, errors);
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
